@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files that carry checks.
// Each macro expects a signal clk in scope; ASSERT_CLK also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/crcfc_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfc_pkg
// Shared constants and types for the CRC-32 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfc_pkg;

    localparam int MAX_PAYLOAD  = 1024;
    localparam int HEADER_BYTES = 16;
    localparam int CRC_BYTES    = 4;

    localparam int COUNT_W = 11;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = LEN_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_VERSION = 2'd1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_SIZE_ERROR  = 3'd4,
        ST_BAD_CRC     = 3'd5
    } frame_status_t;

endpackage

`default_nettype wire

@@ rtl/crcfc_crc_byte.sv @@
// ----------------------------------------------------------------------------
// crcfc_crc_byte
// Reflected CRC-32 update for one data byte, bit at a time, unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfc_crc_byte
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ crcfc_pkg::CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

@@ rtl/crc32_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// crc32_frame_checker_top
// Streaming checker for a length-prefixed frame protected by CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one received byte per beat,
//   with end_of_buffer set on the last byte of the buffer.
//   Output channel (out_valid/out_ready) carries payload bytes as they arrive
//   (is_payload = 1) and, for the last byte, one report (is_payload = 0)
//   holding the frame status and, when the status is OK, the header fields.
//   Header and trailer bytes give no output beat.
//   A result is registered and shows the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless a result waits, limited by the
//   byte-wide CRC update between the running CRC register and its own input.
//   A single output register parts the channels; a new byte is accepted
//   whenever that register is empty or is being taken in the same cycle,
//   so a stalled receiver holds off the sender only while a result waits.
//   Configuration (cfg_valid/cfg_ready, always ready) writes the expected
//   magic (index 0) and version (index 1); other indexes are ignored.
//   Reset clears frame state, output valid flag and both config registers.
//   After each report the frame state returns to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crc32_frame_checker_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [crcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                        cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         rx_byte,
    input  wire logic                               end_of_buffer,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    is_payload,
    output logic [7:0]                              payload_byte,
    output logic [2:0]                              frame_status,
    output logic [7:0]                              message_type,
    output logic [7:0]                              command_code,
    output logic [7:0]                              message_status,
    output logic [15:0]                             sequence_number,
    output logic [15:0]                             payload_length,
    output logic [7:0]                              ack_value
);

    localparam int CW = crcfc_pkg::COUNT_W;
    localparam int LW = crcfc_pkg::LEN_W;
    localparam int SW = crcfc_pkg::SUM_W;

    // Configuration registers.
    logic [31:0]   magic_cfg_reg;
    logic [7:0]    version_cfg_reg;

    // Frame state.
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   crc_reg, crc_next;
    logic [31:0]   magic_reg, magic_next;
    logic [7:0]    version_reg, version_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    command_reg, command_next;
    logic [7:0]    mstatus_reg, mstatus_next;
    logic [LW-1:0] sequence_reg, sequence_next;
    logic [LW-1:0] length_reg, length_next;
    logic [7:0]    ack_reg, ack_next;
    logic [31:0]   rcrc_reg, rcrc_next;

    // Output register.
    logic          out_valid_reg;
    logic          out_payload_reg;
    logic [7:0]    out_byte_reg;
    crcfc_pkg::frame_status_t out_status_reg;
    logic [7:0]    out_type_reg;
    logic [7:0]    out_command_reg;
    logic [7:0]    out_mstatus_reg;
    logic [LW-1:0] out_sequence_reg;
    logic [LW-1:0] out_length_reg;
    logic [7:0]    out_ack_reg;

    logic [31:0]   crc_upd;
    logic          in_fire;
    logic          len_ok;
    logic          in_crc;
    logic          emit_payload;
    logic [SW-1:0] crc_end;
    logic [SW-1:0] frame_total;
    crcfc_pkg::frame_status_t status_calc;

    crcfc_crc_byte u_crc
    (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        type_next     = type_reg;
        command_next  = command_reg;
        mstatus_next  = mstatus_reg;
        sequence_next = sequence_reg;
        length_next   = length_reg;
        ack_next      = ack_reg;

        case (count_reg)
            11'd0:   magic_next[7:0]      = rx_byte;
            11'd1:   magic_next[15:8]     = rx_byte;
            11'd2:   magic_next[23:16]    = rx_byte;
            11'd3:   magic_next[31:24]    = rx_byte;
            11'd4:   version_next         = rx_byte;
            11'd5:   type_next            = rx_byte;
            11'd6:   command_next         = rx_byte;
            11'd7:   mstatus_next         = rx_byte;
            11'd8:   sequence_next[7:0]   = rx_byte;
            11'd9:   sequence_next[15:8]  = rx_byte;
            11'd10:  length_next[7:0]     = rx_byte;
            11'd11:  length_next[15:8]    = rx_byte;
            11'd12:  ack_next             = rx_byte;
            default: ;
        endcase

        len_ok  = length_next <= LW'(crcfc_pkg::MAX_PAYLOAD);
        crc_end = SW'(crcfc_pkg::HEADER_BYTES) + {1'b0, length_next};
        in_crc  = {{(SW-CW){1'b0}}, count_reg} < crc_end;

        crc_next   = in_crc ? crc_upd : crc_reg;
        rcrc_next  = {rx_byte, rcrc_reg[31:8]};
        count_next = (count_reg < crcfc_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        emit_payload = len_ok && in_crc
                    && (count_reg >= CW'(crcfc_pkg::HEADER_BYTES));

        // Frame size after this byte against header, payload and CRC.
        frame_total = {{(SW-CW){1'b0}}, count_next};

        if (count_next < CW'(crcfc_pkg::HEADER_BYTES + crcfc_pkg::CRC_BYTES))
        begin
            status_calc = crcfc_pkg::ST_SHORT;
        end
        else if (magic_next != magic_cfg_reg)
        begin
            status_calc = crcfc_pkg::ST_BAD_MAGIC;
        end
        else if (version_next != version_cfg_reg)
        begin
            status_calc = crcfc_pkg::ST_BAD_VERSION;
        end
        else if (!len_ok)
        begin
            status_calc = crcfc_pkg::ST_SIZE_ERROR;
        end
        else if (frame_total != SW'(crcfc_pkg::HEADER_BYTES + crcfc_pkg::CRC_BYTES)
                                + {1'b0, length_next})
        begin
            status_calc = crcfc_pkg::ST_SIZE_ERROR;
        end
        else if (~crc_next != rcrc_next)
        begin
            status_calc = crcfc_pkg::ST_BAD_CRC;
        end
        else
        begin
            status_calc = crcfc_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_cfg_reg   <= '0;
            version_cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crcfc_pkg::CFG_FRAME_MAGIC:   magic_cfg_reg   <= cfg_data;
                crcfc_pkg::CFG_FRAME_VERSION: version_cfg_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            crc_reg      <= crcfc_pkg::CRC_INIT;
            magic_reg    <= '0;
            version_reg  <= '0;
            type_reg     <= '0;
            command_reg  <= '0;
            mstatus_reg  <= '0;
            sequence_reg <= '0;
            length_reg   <= '0;
            ack_reg      <= '0;
            rcrc_reg     <= '0;
        end
        else if (in_fire)
        begin
            if (end_of_buffer)
            begin
                // The report closes the frame; start the next one afresh.
                count_reg    <= '0;
                crc_reg      <= crcfc_pkg::CRC_INIT;
                magic_reg    <= '0;
                version_reg  <= '0;
                type_reg     <= '0;
                command_reg  <= '0;
                mstatus_reg  <= '0;
                sequence_reg <= '0;
                length_reg   <= '0;
                ack_reg      <= '0;
                rcrc_reg     <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                crc_reg      <= crc_next;
                magic_reg    <= magic_next;
                version_reg  <= version_next;
                type_reg     <= type_next;
                command_reg  <= command_next;
                mstatus_reg  <= mstatus_next;
                sequence_reg <= sequence_next;
                length_reg   <= length_next;
                ack_reg      <= ack_next;
                rcrc_reg     <= rcrc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && (end_of_buffer || emit_payload))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && end_of_buffer)
        begin
            out_payload_reg <= 1'b0;
            out_byte_reg    <= '0;
            out_status_reg  <= status_calc;
            if (status_calc == crcfc_pkg::ST_OK)
            begin
                out_type_reg     <= type_next;
                out_command_reg  <= command_next;
                out_mstatus_reg  <= mstatus_next;
                out_sequence_reg <= sequence_next;
                out_length_reg   <= length_next;
                out_ack_reg      <= ack_next;
            end
            else
            begin
                out_type_reg     <= '0;
                out_command_reg  <= '0;
                out_mstatus_reg  <= '0;
                out_sequence_reg <= '0;
                out_length_reg   <= '0;
                out_ack_reg      <= '0;
            end
        end
        else if (in_fire && emit_payload)
        begin
            out_payload_reg  <= 1'b1;
            out_byte_reg     <= rx_byte;
            out_status_reg   <= crcfc_pkg::ST_OK;
            out_type_reg     <= '0;
            out_command_reg  <= '0;
            out_mstatus_reg  <= '0;
            out_sequence_reg <= '0;
            out_length_reg   <= '0;
            out_ack_reg      <= '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign is_payload      = out_payload_reg;
    assign payload_byte    = out_byte_reg;
    assign frame_status    = out_status_reg;
    assign message_type    = out_type_reg;
    assign command_code    = out_command_reg;
    assign message_status  = out_mstatus_reg;
    assign sequence_number = out_sequence_reg;
    assign payload_length  = out_length_reg;
    assign ack_value       = out_ack_reg;

    // A waiting result must hold off the input side.
    `ASSERT_CLK(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready, "input taken while result stalled")
    // The last byte always yields a report beat next cycle.
    `ASSERT_CLK(a_last_gives_report, (in_fire && end_of_buffer) |=> (out_valid && !is_payload), "no report after last byte")
    // After a report the frame state is back at its start values.
    `ASSERT_CLK(a_frame_cleared, (in_fire && end_of_buffer) |=> (count_reg == '0 && crc_reg == crcfc_pkg::CRC_INIT), "frame state not cleared")
    // Payload beats always carry the OK status.
    `ASSERT_CLK(a_payload_status_ok, (out_valid && is_payload) |-> (frame_status == crcfc_pkg::ST_OK), "payload beat with status")

endmodule

`default_nettype wire

@@ bench/crc32_frame_checker_top_test.sv @@
`timescale 1ns / 100ps

// ---------------------------------------------------------------------------
// CRC-32 frame checker bench
// Sends byte streams built as length-prefixed frames and runs a byte-level
// model of the checker beside the block. Every payload and report beat is
// compared with the model. The input idles and the output stalls at random.
// ---------------------------------------------------------------------------
module crc32_frame_checker_top_test;

    localparam logic [crcfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [crcfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_BYTES   = 60;

    typedef enum logic [1:0] { STIM_BYTE, STIM_CFG, STIM_DRAIN } stim_kind_t;
    typedef enum logic [2:0] {
        FAULT_NONE, FAULT_CRC, FAULT_BIT, FAULT_TRUNCATE, FAULT_EXTEND
    } frame_fault_t;

    typedef struct packed {
        stim_kind_t                           kind;
        logic [7:0]                           data;
        logic                                 last;
        logic [crcfc_pkg::CFG_IDX_W-1:0]      idx;
        logic [31:0]                          value;
    } link_step_t;

    typedef struct packed {
        logic                     is_payload;
        logic [7:0]               payload_byte;
        crcfc_pkg::frame_status_t status;
        logic [7:0]               message_type;
        logic [7:0]               command_code;
        logic [7:0]               message_status;
        logic [15:0]              sequence_number;
        logic [15:0]              payload_length;
        logic [7:0]               ack_value;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [crcfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                     cfg_data = '0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = '0;
    logic       end_of_buffer = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [7:0]  message_type;
    logic [7:0]  command_code;
    logic [7:0]  message_status;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
    logic [7:0]  ack_value;

    crc32_frame_checker_top u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .end_of_buffer   (end_of_buffer),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_payload      (is_payload),
        .payload_byte    (payload_byte),
        .frame_status    (frame_status),
        .message_type    (message_type),
        .command_code    (command_code),
        .message_status  (message_status),
        .sequence_number (sequence_number),
        .payload_length  (payload_length),
        .ack_value       (ack_value)
    );

    link_step_t    link_script[$];
    frame_result_t awaited_results[$];
    int unsigned   queued_bytes = 0;
    int unsigned   mismatches = 0;

    // Register values as the script will have left them, used when building frames.
    logic [31:0] plan_magic = '0;
    logic [7:0]  plan_version = '0;

    // Model of the checker, advanced on each accepted beat.
    logic [31:0]                   cfg_magic_q = '0;
    logic [7:0]                    cfg_version_q = '0;
    logic [crcfc_pkg::COUNT_W-1:0] pos_count;
    logic [31:0]                   run_crc;
    logic [31:0]                   cap_magic;
    logic [7:0]                    cap_version;
    logic [7:0]                    cap_type;
    logic [7:0]                    cap_command;
    logic [7:0]                    cap_status;
    logic [15:0]                   cap_sequence;
    logic [15:0]                   cap_length;
    logic [7:0]                    cap_ack;
    logic [31:0]                   trailer_word;

    int unsigned send_gap = 0;
    int unsigned settle_left = SETTLE_CYCLES;
    int unsigned tx_calm_left = 0;
    int unsigned stall_left = 0;
    int unsigned rx_calm_left = 0;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ crcfc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(16, 40);
    endfunction

    task automatic start_frame();
        pos_count    = '0;
        run_crc      = crcfc_pkg::CRC_INIT;
        cap_magic    = '0;
        cap_version  = '0;
        cap_type     = '0;
        cap_command  = '0;
        cap_status   = '0;
        cap_sequence = '0;
        cap_length   = '0;
        cap_ack      = '0;
        trailer_word = '0;
    endtask

    task automatic write_register(input logic [crcfc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] value);
        if (idx == crcfc_pkg::CFG_FRAME_MAGIC)
            cfg_magic_q = value;
        else if (idx == crcfc_pkg::CFG_FRAME_VERSION)
            cfg_version_q = value[7:0];
    endtask

    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        int unsigned              pos;
        int unsigned              body_end;
        int unsigned              total;
        logic                     len_ok;
        crcfc_pkg::frame_status_t st;
        frame_result_t            res;
        pos = pos_count;
        case (pos)
            0:  cap_magic[7:0]     = b;
            1:  cap_magic[15:8]    = b;
            2:  cap_magic[23:16]   = b;
            3:  cap_magic[31:24]   = b;
            4:  cap_version        = b;
            5:  cap_type           = b;
            6:  cap_command        = b;
            7:  cap_status         = b;
            8:  cap_sequence[7:0]  = b;
            9:  cap_sequence[15:8] = b;
            10: cap_length[7:0]    = b;
            11: cap_length[15:8]   = b;
            12: cap_ack            = b;
            default: ;
        endcase
        len_ok   = cap_length <= crcfc_pkg::MAX_PAYLOAD;
        body_end = crcfc_pkg::HEADER_BYTES + cap_length;
        // The CRC covers header and payload only; the trailer shifts into its own word.
        if (pos < body_end)
            run_crc = crc32_byte(run_crc, b);
        trailer_word = {b, trailer_word[31:8]};
        if (pos_count != crcfc_pkg::COUNT_MAX)
            pos_count = pos_count + 1'b1;
        res = '0;
        if (!last)
        begin
            if (len_ok && pos >= crcfc_pkg::HEADER_BYTES && pos < body_end)
            begin
                res.is_payload   = 1'b1;
                res.payload_byte = b;
                awaited_results.push_back(res);
            end
        end
        else
        begin
            total = pos_count;
            if (total < crcfc_pkg::HEADER_BYTES + crcfc_pkg::CRC_BYTES)
                st = crcfc_pkg::ST_SHORT;
            else if (cap_magic != cfg_magic_q)
                st = crcfc_pkg::ST_BAD_MAGIC;
            else if (cap_version != cfg_version_q)
                st = crcfc_pkg::ST_BAD_VERSION;
            else if (!len_ok)
                st = crcfc_pkg::ST_SIZE_ERROR;
            else if (total != crcfc_pkg::HEADER_BYTES + crcfc_pkg::CRC_BYTES + cap_length)
                st = crcfc_pkg::ST_SIZE_ERROR;
            else if (~run_crc != trailer_word)
                st = crcfc_pkg::ST_BAD_CRC;
            else
                st = crcfc_pkg::ST_OK;
            res.status = st;
            if (st == crcfc_pkg::ST_OK)
            begin
                res.message_type    = cap_type;
                res.command_code    = cap_command;
                res.message_status  = cap_status;
                res.sequence_number = cap_sequence;
                res.payload_length  = cap_length;
                res.ack_value       = cap_ack;
            end
            awaited_results.push_back(res);
            start_frame();
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        link_step_t s;
        s      = '0;
        s.kind = STIM_BYTE;
        s.data = b;
        s.last = last;
        link_script.push_back(s);
        queued_bytes++;
    endtask

    task automatic add_cfg(input logic [crcfc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
        link_step_t s;
        s       = '0;
        s.kind  = STIM_CFG;
        s.idx   = idx;
        s.value = value;
        link_script.push_back(s);
        if (idx == crcfc_pkg::CFG_FRAME_MAGIC)
            plan_magic = value;
        else if (idx == crcfc_pkg::CFG_FRAME_VERSION)
            plan_version = value[7:0];
    endtask

    // The sender holds off here until every awaited result has come back.
    task automatic add_drain();
        link_step_t s;
        s      = '0;
        s.kind = STIM_DRAIN;
        link_script.push_back(s);
    endtask

    task automatic add_frame(input logic [31:0] magic, input logic [7:0] version,
                             input logic [15:0] len_field, input int unsigned body_len,
                             input frame_fault_t fault, input int unsigned extra);
        logic [7:0]  fb[$];
        logic [31:0] crc;
        int unsigned pos;
        int unsigned n;
        for (int i = 0; i < 4; i++)
        begin
            fb.push_back(magic[8*i +: 8]);
        end
        fb.push_back(version);
        repeat (5) fb.push_back(8'($urandom));
        fb.push_back(len_field[7:0]);
        fb.push_back(len_field[15:8]);
        repeat (4) fb.push_back(8'($urandom));
        repeat (body_len) fb.push_back(8'($urandom));
        crc = crcfc_pkg::CRC_INIT;
        foreach (fb[i])
        begin
            crc = crc32_byte(crc, fb[i]);
        end
        crc = ~crc;
        for (int i = 0; i < 4; i++)
        begin
            fb.push_back(crc[8*i +: 8]);
        end
        case (fault)
            FAULT_CRC:
            begin
                pos = fb.size() - 1 - $urandom_range(0, 3);
                fb[pos] = fb[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            FAULT_BIT:
            begin
                pos = $urandom_range(0, fb.size() - 5);
                fb[pos] = fb[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            FAULT_TRUNCATE:
            begin
                if (extra != 0)
                    n = extra;
                else if ($urandom_range(0, 1) != 0)
                    n = $urandom_range(1, 4);
                else
                    n = $urandom_range(1, fb.size() - 1);
                repeat (n) void'(fb.pop_back());
            end
            FAULT_EXTEND:
            begin
                n = (extra != 0) ? extra : $urandom_range(1, 6);
                repeat (n) fb.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (fb[i])
        begin
            add_byte(fb[i], i == fb.size() - 1);
        end
    endtask

    task automatic add_random_frame();
        int unsigned pick;
        int unsigned body;
        int unsigned n;
        pick = $urandom_range(0, 99);
        body = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 80);
        if (pick < 55)
            add_frame(plan_magic, plan_version, 16'(body), body, FAULT_NONE, 0);
        else if (pick < 63)
            add_frame(plan_magic, plan_version, 16'(body), body, FAULT_CRC, 0);
        else if (pick < 69)
            add_frame(plan_magic, plan_version, 16'(body), body, FAULT_BIT, 0);
        else if (pick < 75)
            add_frame(plan_magic, plan_version, 16'(body), body, FAULT_TRUNCATE, 0);
        else if (pick < 80)
            add_frame(plan_magic, plan_version, 16'(body), body, FAULT_EXTEND, 0);
        else if (pick < 85)
            add_frame(plan_magic ^ (32'd1 << $urandom_range(0, 31)), plan_version,
                      16'(body), body, FAULT_NONE, 0);
        else if (pick < 89)
            add_frame(plan_magic, plan_version ^ (8'd1 << $urandom_range(0, 7)),
                      16'(body), body, FAULT_NONE, 0);
        else if (pick < 94)
            add_frame(plan_magic, plan_version,
                      16'($urandom_range(crcfc_pkg::MAX_PAYLOAD + 1, 65535)),
                      $urandom_range(0, 8), FAULT_NONE, 0);
        else
        begin
            // Line noise: a short buffer of arbitrary bytes.
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
            begin
                add_byte(8'($urandom), i == n - 1);
            end
        end
    endtask

    task automatic configure_phase(input int unsigned phase);
        add_drain();
        case (phase)
            0:
            begin
                add_cfg(CFG_SPARE_2, $urandom);
                add_cfg(CFG_SPARE_3, $urandom);
                add_cfg(crcfc_pkg::CFG_FRAME_MAGIC, 32'hffff_ffff);
                add_cfg(crcfc_pkg::CFG_FRAME_VERSION, 32'hff);
            end
            1:
            begin
                add_cfg(crcfc_pkg::CFG_FRAME_MAGIC, 32'h0);
                add_cfg(crcfc_pkg::CFG_FRAME_VERSION, 32'h0);
            end
            default:
            begin
                add_cfg(crcfc_pkg::CFG_FRAME_MAGIC, $urandom);
                add_cfg(crcfc_pkg::CFG_FRAME_VERSION, $urandom);
                if ($urandom_range(0, 1) != 0)
                    add_cfg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin : drive_proc
        logic       next_in_valid;
        logic       next_cfg_valid;
        link_step_t head;
        if (rst_n)
        begin
            next_in_valid  = in_valid;
            next_cfg_valid = cfg_valid;
            if (in_valid && in_ready)
            begin
                track_frame_byte(rx_byte, end_of_buffer);
                void'(link_script.pop_front());
                next_in_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_index, cfg_data);
                void'(link_script.pop_front());
                next_cfg_valid = 1'b0;
            end
            if (tx_calm_left != 0)
                tx_calm_left--;
            else if ($urandom_range(0, 299) == 0)
                tx_calm_left = $urandom_range(50, 250);
            if (!next_in_valid && !next_cfg_valid && link_script.size() != 0)
            begin
                head = link_script[0];
                if (send_gap != 0)
                    send_gap--;
                else
                begin
                    case (head.kind)
                        STIM_BYTE:
                        begin
                            next_in_valid = 1'b1;
                            rx_byte       <= head.data;
                            end_of_buffer <= head.last;
                            send_gap = (tx_calm_left != 0) ? 0 : idle_span();
                        end
                        STIM_CFG:
                        begin
                            next_cfg_valid = 1'b1;
                            cfg_index      <= head.idx;
                            cfg_data       <= head.value;
                        end
                        default:
                        begin
                            // A trailing byte may still be in flight without a result.
                            if (awaited_results.size() != 0)
                                settle_left = SETTLE_CYCLES;
                            else if (settle_left != 0)
                                settle_left--;
                            else
                            begin
                                void'(link_script.pop_front());
                                settle_left = SETTLE_CYCLES;
                            end
                        end
                    endcase
                end
            end
            in_valid  <= next_in_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    always @(posedge clk)
    begin : watch_proc
        logic          next_ready;
        frame_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with nothing awaited");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("is_payload", want.is_payload, is_payload);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("frame_status", want.status, frame_status);
                    check_field("message_type", want.message_type, message_type);
                    check_field("command_code", want.command_code, command_code);
                    check_field("message_status", want.message_status, message_status);
                    check_field("sequence_number", want.sequence_number, sequence_number);
                    check_field("payload_length", want.payload_length, payload_length);
                    check_field("ack_value", want.ack_value, ack_value);
                end
            end
            if (rx_calm_left != 0)
                rx_calm_left--;
            else if ($urandom_range(0, 299) == 0)
                rx_calm_left = $urandom_range(50, 250);
            if (stall_left != 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                next_ready = 1'b1;
                if (rx_calm_left == 0 && $urandom_range(0, 2) == 0)
                    stall_left = idle_span();
            end
            out_ready <= next_ready;
        end
    end

    initial
    begin
        int unsigned phase_start;
        start_frame();

        // Directed: a one-byte buffer, then a minimal frame under reset settings.
        add_byte(8'hff, 1'b1);
        add_frame(32'h0, 8'h0, 16'h0, 0, FAULT_NONE, 0);

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            configure_phase(phase);
            if (phase == 2)
            begin
                // A length field at the largest legal value over a short body, then
                // two length fields just and far beyond the limit.
                add_frame(plan_magic, plan_version, 16'(crcfc_pkg::MAX_PAYLOAD), 40,
                          FAULT_NONE, 0);
                add_frame(plan_magic, plan_version, 16'(crcfc_pkg::MAX_PAYLOAD + 1), 0,
                          FAULT_NONE, 0);
                add_frame(plan_magic, plan_version, 16'hffff, 3, FAULT_NONE, 0);
            end
            phase_start = queued_bytes;
            while (queued_bytes - phase_start < PHASE_BYTES)
            begin
                add_random_frame();
            end
        end
        add_drain();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (link_script.size() != 0 || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
